// ===== rtl/core/edt_pkg.sv =====
// euclidean distance table: shared types and constants
`timescale 1ns / 1ps

package edt_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W = 6;
    localparam int DIST_W = 25;
    localparam int STATUS_W = 2;
    localparam int OP_W = 2;
    localparam int FRAC_BITS = 8;

    localparam int MARK_N = 2 ** IDX_W;
    localparam int SQR_W = 2 * COORD_W;
    localparam int SUM_W = SQR_W + 1;
    localparam int WIDE_W = SUM_W + 33;
    localparam int RAD_W = 2 * DIST_W;
    localparam int REM_W = DIST_W + 2;

    localparam int SQ_STEPS = 5;
    localparam int SQ_STAGES = DIST_W / SQ_STEPS;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FINITE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INF = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [REM_W-1:0]    rem;
        logic [DIST_W-1:0]   root;
        logic [STATUS_W-1:0] status;
        logic                sat;
    } t_sq;

endpackage

// ===== rtl/core/euclidean_distance_table_core.sv =====
// euclidean distance table: point memory, query pipeline and square root
`timescale 1ns / 1ps
// throughput: one item per cycle while o_stall is low; loads and marks update state at acceptance
// pipeline: two-port point memory read, squares, sum into the square root entry, 5 square root stages (5 bits each)
// stalls freeze only full stages, so bubbles close up behind a stalled result
// reset clears the point count, all unreachable marks and every stage valid

module euclidean_distance_table_core
    import edt_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [OP_W-1:0]            i_opcode,
    input  logic                       i_first_point,
    input  logic signed [COORD_W-1:0]  i_x_coord,
    input  logic signed [COORD_W-1:0]  i_y_coord,
    input  logic [IDX_W-1:0]           i_from_index,
    input  logic [IDX_W-1:0]           i_to_index,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [DIST_W-1:0]          o_distance,
    output logic [STATUS_W-1:0]        o_status
);

    // widths that follow from the store depth
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    // stage 0 memory read, stage 1 squares, stages 2.. square root entry and steps
    localparam int NST = 3 + SQ_STAGES;

    // point memory, x in the upper half
    logic [SQR_W-1:0] mem [0:MAX_POINTS-1];

    logic [CNT_W-1:0]  r_count;
    logic [MARK_N-1:0] r_marks;

    logic [NST-1:0] r_v;
    logic           r_out_valid;

    // stage 0
    logic [SQR_W-1:0]    r_s0_a;
    logic [SQR_W-1:0]    r_s0_b;
    logic [STATUS_W-1:0] r_s0_status;
    // stage 1
    logic [SQR_W-1:0]    r_s1_sqx;
    logic [SQR_W-1:0]    r_s1_sqy;
    logic [STATUS_W-1:0] r_s1_status;
    // square root entry and steps
    t_sq r_sq [0:SQ_STAGES];

    logic [DIST_W-1:0]   r_dist;
    logic [STATUS_W-1:0] r_status;

    logic [NST-1:0] w_adv;
    logic           w_adv_out;
    logic           w_accept;
    logic [CMP_W-1:0] w_from;
    logic [CMP_W-1:0] w_to;
    logic [CMP_W-1:0] w_cnt;
    logic [AW-1:0]    w_from_addr;
    logic [AW-1:0]    w_to_addr;
    logic [STATUS_W-1:0] w_status;
    logic [CNT_W-1:0] w_base;
    logic             w_store;
    logic [COORD_W:0] w_dx;
    logic [COORD_W:0] w_dy;
    logic [COORD_W-1:0] w_adx;
    logic [COORD_W-1:0] w_ady;
    logic [SUM_W-1:0] w_sum;
    logic [WIDE_W-1:0] w_wide;

    // SQ_STEPS restoring square root steps: two radicand bits in, one root bit out
    function automatic t_sq sq_steps(input t_sq s);
        t_sq o;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] shifted;
        o = s;
        for (int k = 0; k < SQ_STEPS; k++) begin
            shifted = {o.rem, o.rad[RAD_W-1 -: 2]};
            trial = shifted - (REM_W+2)'({o.root, 2'b01});
            if (!trial[REM_W+1]) begin
                o.rem = trial[REM_W-1:0];
                o.root = {o.root[DIST_W-2:0], 1'b1};
            end else begin
                o.rem = shifted[REM_W-1:0];
                o.root = {o.root[DIST_W-2:0], 1'b0};
            end
            o.rad = {o.rad[RAD_W-3:0], 2'b00};
        end
        return o;
    endfunction

    // stage advance, from the output back to the input
    always_comb begin
        w_adv_out = !r_out_valid || !i_stall;
        w_adv[NST-1] = !r_v[NST-1] || w_adv_out;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign o_stall  = !w_adv[0];
    assign w_accept = i_valid && !o_stall;

    // index checks against the current point set
    assign w_from = CMP_W'(i_from_index);
    assign w_to   = CMP_W'(i_to_index);
    assign w_cnt  = CMP_W'(r_count);
    assign w_from_addr = AW'(w_from);
    assign w_to_addr   = AW'(w_to);

    always_comb begin
        if (w_from >= w_cnt || w_to >= w_cnt) begin
            w_status = ST_RANGE;
        end else if (i_from_index == i_to_index || r_marks[i_to_index]) begin
            w_status = ST_INF;
        end else begin
            w_status = ST_FINITE;
        end
    end

    // load slot: a new set restarts at entry zero, a full set drops the point
    assign w_base  = i_first_point ? '0 : r_count;
    assign w_store = w_accept && (i_opcode == OP_LOAD)
                     && (w_base != CNT_W'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem[AW'(w_base)] <= {i_x_coord, i_y_coord};
        end
    end

    // two read ports, registered
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s0_a      <= mem[w_from_addr];
            r_s0_b      <= mem[w_to_addr];
            r_s0_status <= w_status;
        end
    end

    // point count and unreachable marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_marks <= '0;
        end else if (w_accept) begin
            case (i_opcode)
                OP_LOAD: begin
                    if (i_first_point) begin
                        r_marks <= '0;
                    end
                    if (w_store) begin
                        r_count <= w_base + 1'b1;
                    end else begin
                        r_count <= w_base;
                    end
                end
                OP_MARK: begin
                    if (w_to < w_cnt) begin
                        r_marks[i_to_index] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // absolute differences and squares
    assign w_dx = {r_s0_a[SQR_W-1], r_s0_a[SQR_W-1:COORD_W]}
                - {r_s0_b[SQR_W-1], r_s0_b[SQR_W-1:COORD_W]};
    assign w_dy = {r_s0_a[COORD_W-1], r_s0_a[COORD_W-1:0]}
                - {r_s0_b[COORD_W-1], r_s0_b[COORD_W-1:0]};
    assign w_adx = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
    assign w_ady = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1_sqx    <= SQR_W'(w_adx) * SQR_W'(w_adx);
            r_s1_sqy    <= SQR_W'(w_ady) * SQR_W'(w_ady);
            r_s1_status <= r_s0_status;
        end
    end

    // sum, fraction scaling and overflow check
    assign w_sum  = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy};
    assign w_wide = WIDE_W'(w_sum) << (2 * FRAC_BITS);

    // square root entry and stages
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_sq[0].rad    <= w_wide[RAD_W-1:0];
            r_sq[0].rem    <= '0;
            r_sq[0].root   <= '0;
            r_sq[0].status <= r_s1_status;
            r_sq[0].sat    <= |w_wide[WIDE_W-1:RAD_W];
        end
        for (int g = 1; g <= SQ_STAGES; g++) begin
            if (w_adv[2+g]) begin
                r_sq[g] <= sq_steps(r_sq[g-1]);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_status <= r_sq[SQ_STAGES].status;
            case (r_sq[SQ_STAGES].status)
                ST_RANGE: r_dist <= '0;
                ST_INF:   r_dist <= '1;
                default: begin
                    r_dist <= r_sq[SQ_STAGES].sat ? '1 : r_sq[SQ_STAGES].root;
                end
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= w_accept && (i_opcode == OP_QUERY);
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_adv_out) begin
                r_out_valid <= r_v[NST-1];
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_dist;
    assign o_status   = r_status;

endmodule
